// ===== hw/rtl/dfgt_pkg.sv =====
// Shared types and constants of the depth-first graph traversal unit.
package dfgt_pkg;

  localparam int unsigned VtxW   = 4;  // width of a vertex number on the ports
  localparam int unsigned CountW = 5;  // width of the vertex count register
  localparam int unsigned ActW   = 2;

  localparam logic [ActW-1:0] ActAddEdge  = 2'd0;
  localparam logic [ActW-1:0] ActTraverse = 2'd1;
  localparam logic [ActW-1:0] ActClear    = 2'd2;

  localparam logic [CountW-1:0] VertexCountReset = 5'd16;

  typedef enum logic [2:0] {
    StIdle,
    StAddScan,
    StAddCheck,
    StTravOuter,
    StTravTop,
    StTravRead
  } dfgt_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_edge;
    logic clear_lists;
    logic add_read;
    logic add_write;
    logic trav_init;
    logic start_next;
    logic push_start;
    logic top_pop;
    logic top_read;
    logic push_found;
  } dfgt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic edge_out_of_range;
    logic scan_done;
    logic list_full;
    logic scan_match;
    logic start_done;
    logic start_visited;
    logic stack_empty;
    logic top_exhausted;
    logic found_skip;
    logic out_free;
  } dfgt_status_t;

endpackage

// ===== hw/rtl/depth_first_graph_traversal_unit.sv =====
// Top level of the depth-first graph traversal unit.
// Usage: the input channel takes one word per command: add an edge (from_vertex_i to
// to_vertex_i), run a full traversal, or clear all neighbor lists. Each list keeps its
// neighbors in insertion order; an edge already stored, or one with an endpoint at or
// above the vertex count, is dropped. A traversal produces one output word per vertex
// in depth-first order, starting a new walk from each unvisited vertex in index order;
// last_o marks the final word. Add and clear produce no output.
// An add scans the source list one entry per read through the single-port neighbor
// memory, then appends. A traversal fetches every stored neighbor through the same
// port and then checks it. One command is in work at a time; the input is ready again
// once the command finishes. Reset clears all lists and sets the vertex count to 16;
// no clearing pass is needed. When the receiver stalls, a finished word waits in the
// output register and the traversal halts at its next visit until that word is taken.
// The user is to write the vertex count through cfg_we_i/cfg_data_i only while the
// unit is idle; the unit itself does not enforce this.
module depth_first_graph_traversal_unit #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [dfgt_pkg::ActW-1:0]      action_i,
  input  logic [dfgt_pkg::VtxW-1:0]      from_vertex_i,
  input  logic [dfgt_pkg::VtxW-1:0]      to_vertex_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [dfgt_pkg::VtxW-1:0]      visited_vertex_o,
  output logic                           last_o,
  input  logic                           cfg_we_i,
  input  logic [dfgt_pkg::CountW-1:0]    cfg_data_i
);

  dfgt_pkg::dfgt_cmd_t    cmd;
  dfgt_pkg::dfgt_status_t status;

  // The controller sequences each command; the datapath holds all graph state.
  dfgt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dfgt_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .from_vertex_i    (from_vertex_i),
    .to_vertex_i      (to_vertex_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .visited_vertex_o (visited_vertex_o),
    .last_o           (last_o),
    .cmd_i            (cmd),
    .status_o         (status)
  );

endmodule

// ===== hw/rtl/dfgt_ctrl.sv =====
// Controller state machine of the depth-first graph traversal unit.
module dfgt_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [dfgt_pkg::ActW-1:0]    action_i,
  input  dfgt_pkg::dfgt_status_t       status_i,
  output dfgt_pkg::dfgt_cmd_t          cmd_o
);

  dfgt_pkg::dfgt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dfgt_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      dfgt_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (action_i)
            dfgt_pkg::ActAddEdge: begin
              cmd_o.latch_edge = 1'b1;
              state_d          = dfgt_pkg::StAddScan;
            end
            dfgt_pkg::ActTraverse: begin
              cmd_o.trav_init = 1'b1;
              state_d         = dfgt_pkg::StTravOuter;
            end
            dfgt_pkg::ActClear: begin
              cmd_o.clear_lists = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      dfgt_pkg::StAddScan: begin
        if (status_i.edge_out_of_range) begin
          state_d = dfgt_pkg::StIdle;
        end else if (status_i.scan_done) begin
          // Reached the end of the list without a match: append.
          cmd_o.add_write = !status_i.list_full;
          state_d         = dfgt_pkg::StIdle;
        end else begin
          cmd_o.add_read = 1'b1;
          state_d        = dfgt_pkg::StAddCheck;
        end
      end
      dfgt_pkg::StAddCheck: begin
        state_d = status_i.scan_match ? dfgt_pkg::StIdle : dfgt_pkg::StAddScan;
      end
      dfgt_pkg::StTravOuter: begin
        if (status_i.start_done) begin
          state_d = dfgt_pkg::StIdle;
        end else if (status_i.start_visited) begin
          cmd_o.start_next = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.push_start = 1'b1;
          state_d          = dfgt_pkg::StTravTop;
        end
      end
      dfgt_pkg::StTravTop: begin
        if (status_i.stack_empty) begin
          cmd_o.start_next = 1'b1;
          state_d          = dfgt_pkg::StTravOuter;
        end else if (status_i.top_exhausted) begin
          cmd_o.top_pop = 1'b1;
        end else begin
          cmd_o.top_read = 1'b1;
          state_d        = dfgt_pkg::StTravRead;
        end
      end
      dfgt_pkg::StTravRead: begin
        if (status_i.found_skip) begin
          state_d = dfgt_pkg::StTravTop;
        end else if (status_i.out_free) begin
          cmd_o.push_found = 1'b1;
          state_d          = dfgt_pkg::StTravTop;
        end
      end
      default: begin
        state_d = dfgt_pkg::StIdle;
      end
    endcase
  end

endmodule

// ===== hw/rtl/dfgt_datapath.sv =====
// Datapath: neighbor memory, list lengths, visited marks, walk stack and output register.
module dfgt_datapath #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [dfgt_pkg::VtxW-1:0]      from_vertex_i,
  input  logic [dfgt_pkg::VtxW-1:0]      to_vertex_i,
  input  logic                           cfg_we_i,
  input  logic [dfgt_pkg::CountW-1:0]    cfg_data_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [dfgt_pkg::VtxW-1:0]      visited_vertex_o,
  output logic                           last_o,
  input  dfgt_pkg::dfgt_cmd_t            cmd_i,
  output dfgt_pkg::dfgt_status_t         status_o
);

  // Vertices that can ever be in use: bounded by the parameter and by the 4-bit fields.
  localparam int unsigned NumV  = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
  localparam int unsigned VIW   = $clog2(NumV);
  localparam int unsigned Rows  = 1 << VIW;
  localparam int unsigned CW    = $clog2(NumV + 1);
  localparam int unsigned AW    = 2 * VIW;
  localparam logic [dfgt_pkg::CountW-1:0] NumVCount = dfgt_pkg::CountW'(NumV);
  localparam logic [CW-1:0] ListMax = CW'(NumV);

  logic [dfgt_pkg::CountW-1:0] vertex_count_q;
  logic [dfgt_pkg::CountW-1:0] n_eff;

  logic [dfgt_pkg::VtxW-1:0]   src_q, dst_q;
  logic [CW-1:0]               scan_k_q;

  logic [dfgt_pkg::VtxW-1:0]   mem [Rows*Rows];
  logic [dfgt_pkg::VtxW-1:0]   rdata_q;
  logic [AW-1:0]               mem_addr;

  logic [CW-1:0]               counts_q [Rows];
  logic [Rows-1:0]             visited_q;

  logic [VIW-1:0]              stack_v_q   [Rows];
  logic [CW-1:0]               stack_pos_q [Rows];
  logic [CW-1:0]               sp_q;
  logic [CW-1:0]               top_cnt;
  logic [VIW-1:0]              top_idx;
  logic [VIW-1:0]              top_v;
  logic [CW-1:0]               top_k;

  logic [dfgt_pkg::CountW-1:0] start_q;
  logic [dfgt_pkg::CountW-1:0] emitted_q;

  logic                        out_valid_q;
  logic [dfgt_pkg::VtxW-1:0]   out_vertex_q;
  logic                        out_last_q;
  logic                        out_load;
  logic [dfgt_pkg::VtxW-1:0]   out_vertex_d;

  logic [VIW-1:0]              src_idx, start_idx, found_idx;

  assign n_eff     = (vertex_count_q > NumVCount) ? NumVCount : vertex_count_q;
  assign src_idx   = src_q[VIW-1:0];
  assign start_idx = start_q[VIW-1:0];
  assign found_idx = rdata_q[VIW-1:0];

  assign top_cnt = sp_q - CW'(1);
  assign top_idx = top_cnt[VIW-1:0];
  assign top_v   = stack_v_q[top_idx];
  assign top_k   = stack_pos_q[top_idx];

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= dfgt_pkg::VertexCountReset;
    end else if (cfg_we_i) begin
      vertex_count_q <= cfg_data_i;
    end
  end

  // Edge being added and the scan position along its source list.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_edge) begin
      src_q    <= from_vertex_i;
      dst_q    <= to_vertex_i;
      scan_k_q <= '0;
    end else if (cmd_i.add_read) begin
      scan_k_q <= scan_k_q + CW'(1);
    end
  end

  // Neighbor memory: one port, registered read.
  always_comb begin
    if (cmd_i.add_read || cmd_i.add_write) begin
      mem_addr = {src_idx, scan_k_q[VIW-1:0]};
    end else begin
      mem_addr = {top_v, top_k[VIW-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_write) begin
      mem[mem_addr] <= dst_q;
    end
    if (cmd_i.add_read || cmd_i.top_read) begin
      rdata_q <= mem[mem_addr];
    end
  end

  // List lengths.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counts_q <= '{default: '0};
    end else if (cmd_i.clear_lists) begin
      counts_q <= '{default: '0};
    end else if (cmd_i.add_write) begin
      counts_q[src_idx] <= counts_q[src_idx] + CW'(1);
    end
  end

  // Visited marks, outer start vertex and emitted count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q <= '0;
      start_q   <= '0;
      emitted_q <= '0;
      sp_q      <= '0;
    end else begin
      if (cmd_i.trav_init) begin
        visited_q <= '0;
        start_q   <= '0;
        emitted_q <= '0;
        sp_q      <= '0;
      end
      if (cmd_i.start_next) begin
        start_q <= start_q + dfgt_pkg::CountW'(1);
      end
      if (cmd_i.push_start) begin
        visited_q[start_idx] <= 1'b1;
        emitted_q            <= emitted_q + dfgt_pkg::CountW'(1);
        sp_q                 <= CW'(1);
      end
      if (cmd_i.push_found) begin
        visited_q[found_idx] <= 1'b1;
        emitted_q            <= emitted_q + dfgt_pkg::CountW'(1);
        sp_q                 <= sp_q + CW'(1);
      end
      if (cmd_i.top_pop) begin
        sp_q <= top_cnt;
      end
    end
  end

  // Walk stack entries.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_start) begin
      stack_v_q[0]   <= start_idx;
      stack_pos_q[0] <= '0;
    end
    if (cmd_i.push_found) begin
      stack_v_q[sp_q[VIW-1:0]]   <= found_idx;
      stack_pos_q[sp_q[VIW-1:0]] <= '0;
    end
    if (cmd_i.top_read) begin
      stack_pos_q[top_idx] <= top_k + CW'(1);
    end
  end

  // Output register. Every vertex below the count is visited exactly once,
  // so the final word is the one that brings the emitted count up to it.
  assign out_load     = cmd_i.push_start || cmd_i.push_found;
  assign out_vertex_d = cmd_i.push_start ? start_q[dfgt_pkg::VtxW-1:0] : rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_vertex_q <= out_vertex_d;
      out_last_q   <= (emitted_q + dfgt_pkg::CountW'(1)) == n_eff;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign visited_vertex_o = out_vertex_q;
  assign last_o           = out_last_q;

  always_comb begin
    status_o.edge_out_of_range = ({1'b0, src_q} >= n_eff) || ({1'b0, dst_q} >= n_eff);
    status_o.scan_done         = scan_k_q == counts_q[src_idx];
    status_o.list_full         = counts_q[src_idx] == ListMax;
    status_o.scan_match        = rdata_q == dst_q;
    status_o.start_done        = start_q == n_eff;
    status_o.start_visited     = visited_q[start_idx];
    status_o.stack_empty       = sp_q == '0;
    status_o.top_exhausted     = top_k >= counts_q[top_v];
    status_o.found_skip        = ({1'b0, rdata_q} >= n_eff) || visited_q[found_idx];
    status_o.out_free          = !out_valid_q || out_ready_i;
  end

endmodule

// ===== verif/depth_first_graph_traversal_unit_tb.sv =====
// Self-checking testbench for the depth-first graph traversal unit.
module depth_first_graph_traversal_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxVtx = 16;
  // Action code 3 has no meaning in the unit; it must be swallowed without output.
  localparam logic [dfgt_pkg::ActW-1:0] ActUnused = 2'd3;
  // A traversal can keep scanning stored neighbors after its last visit word has
  // left, so before touching the vertex count we let the worst case run out.
  localparam int unsigned SettleCycles = 700;

  typedef struct packed {
    logic [dfgt_pkg::VtxW-1:0] vertex;
    logic                      last;
  } visit_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [dfgt_pkg::ActW-1:0]   action_i;
  logic [dfgt_pkg::VtxW-1:0]   from_vertex_i;
  logic [dfgt_pkg::VtxW-1:0]   to_vertex_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [dfgt_pkg::VtxW-1:0]   visited_vertex_o;
  logic                        last_o;
  logic                        cfg_we_i;
  logic [dfgt_pkg::CountW-1:0] cfg_data_i;

  // Shadow copy of the graph that the unit is expected to hold.
  logic [dfgt_pkg::VtxW-1:0]   adj_vertex [MaxVtx][MaxVtx];
  int unsigned                 adj_len    [MaxVtx];
  logic [dfgt_pkg::CountW-1:0] shadow_count;

  visit_t pending_visits [$];
  int     mismatch_count;
  bit     gapless;  // when set, neither side inserts idle cycles

  depth_first_graph_traversal_unit #(
    .MAX_VERTICES(MaxVtx)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .from_vertex_i   (from_vertex_i),
    .to_vertex_i     (to_vertex_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .visited_vertex_o(visited_vertex_o),
    .last_o          (last_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the unit hangs; far beyond the slowest legal run.
  initial begin
    #30_000_000;
    $display("depth_first_graph_traversal_unit_tb: errors");
    $finish;
  end

  // The register is five bits wide, but no more than sixteen vertices can ever be
  // in use, so larger values behave like sixteen.
  function automatic int unsigned live_vertices();
    int unsigned n;
    n = shadow_count;
    if (n > MaxVtx) n = MaxVtx;
    return n;
  endfunction

  function automatic int draw_gap();
    if (gapless) return 0;
    return $urandom_range(0, 9);
  endfunction

  // Appends an edge unless an endpoint is out of range, the edge is already
  // stored, or the source list is full.
  function automatic void store_edge(logic [dfgt_pkg::VtxW-1:0] src,
                                     logic [dfgt_pkg::VtxW-1:0] dst);
    int unsigned n;
    n = live_vertices();
    if (src >= n || dst >= n) return;
    if (adj_len[src] >= MaxVtx) return;
    for (int k = 0; k < adj_len[src]; k++) begin
      if (adj_vertex[src][k] == dst) return;
    end
    adj_vertex[src][adj_len[src]] = dst;
    adj_len[src]++;
  endfunction

  // Walks the shadow graph depth first with an explicit stack and queues one
  // visit word per vertex reached; the final word carries the last flag.
  function automatic void queue_dfs_order();
    int unsigned               n;
    int unsigned               emitted;
    int unsigned               depth;
    int unsigned               pos;
    logic [15:0]               seen;
    logic [dfgt_pkg::VtxW-1:0] order    [MaxVtx];
    logic [dfgt_pkg::VtxW-1:0] stk_vtx  [MaxVtx];
    int unsigned               stk_pos  [MaxVtx];
    logic [dfgt_pkg::VtxW-1:0] u;
    logic [dfgt_pkg::VtxW-1:0] w;
    visit_t                    item;
    n = live_vertices();
    emitted = 0;
    seen = '0;
    for (int unsigned s = 0; s < n; s++) begin
      if (!seen[s]) begin
        seen[s] = 1'b1;
        order[emitted] = dfgt_pkg::VtxW'(s);
        emitted++;
        stk_vtx[0] = dfgt_pkg::VtxW'(s);
        stk_pos[0] = 0;
        depth = 1;
        while (depth > 0) begin
          u = stk_vtx[depth-1];
          pos = stk_pos[depth-1];
          if (pos >= adj_len[u]) begin
            depth--;
          end else begin
            stk_pos[depth-1] = pos + 1;
            w = adj_vertex[u][pos];
            // Neighbors left over from a larger vertex count are skipped.
            if (w < n && !seen[w]) begin
              seen[w] = 1'b1;
              order[emitted] = w;
              emitted++;
              if (depth < MaxVtx) begin
                stk_vtx[depth] = w;
                stk_pos[depth] = 0;
                depth++;
              end
            end
          end
        end
      end
    end
    for (int unsigned i = 0; i < emitted; i++) begin
      item.vertex = order[i];
      item.last = (i == emitted - 1);
      pending_visits.insert(pending_visits.size(), item);
    end
  endfunction

  function automatic void apply_command(logic [dfgt_pkg::ActW-1:0] act,
                                        logic [dfgt_pkg::VtxW-1:0] src,
                                        logic [dfgt_pkg::VtxW-1:0] dst);
    case (act)
      dfgt_pkg::ActAddEdge: begin
        store_edge(src, dst);
      end
      dfgt_pkg::ActTraverse: begin
        queue_dfs_order();
      end
      dfgt_pkg::ActClear: begin
        for (int i = 0; i < MaxVtx; i++) adj_len[i] = 0;
      end
      default: begin
      end
    endcase
  endfunction

  // Sends one command word. The task is entered and left at a falling edge; valid is
  // left high after acceptance so that a back-to-back word needs no extra toggle.
  task automatic send_word(input logic [dfgt_pkg::ActW-1:0] act,
                           input logic [dfgt_pkg::VtxW-1:0] src,
                           input logic [dfgt_pkg::VtxW-1:0] dst);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    action_i      = act;
    from_vertex_i = src;
    to_vertex_i   = dst;
    do @(posedge clk_i); while (!in_ready_o);
    apply_command(act, src, dst);
    @(negedge clk_i);
  endtask

  // Holds the input off until every visit word is back. Adds and clears give no
  // output, so a fixed settling time follows before the unit counts as idle.
  task automatic drain_and_settle();
    in_valid_i = 1'b0;
    while (pending_visits.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_vertex_count(input logic [dfgt_pkg::CountW-1:0] value);
    drain_and_settle();
    cfg_we_i   = 1'b1;
    cfg_data_i = value;
    @(posedge clk_i);
    shadow_count = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Receiver: draws a stall before each word, then holds ready until one is taken.
  initial begin : receiver
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = draw_gap();
      if (stall != 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Every word taken from the output is matched against the oldest prediction.
  always @(posedge clk_i) begin
    visit_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_visits.size() == 0) begin
        $error("unexpected output word: visited_vertex %0d last %0d",
               visited_vertex_o, last_o);
        mismatch_count++;
      end else begin
        want = pending_visits.pop_front();
        if (visited_vertex_o !== want.vertex) begin
          $error("visited_vertex: expected %0d, actual %0d", want.vertex, visited_vertex_o);
          mismatch_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, last_o);
          mismatch_count++;
        end
      end
    end
  end

  // With no edges every vertex is its own walk; then a cycle, a duplicate,
  // a self loop, the unused action and a clear are exercised.
  task automatic test_basic_walks();
    send_word(dfgt_pkg::ActTraverse, 4'd0, 4'd0);
    send_word(dfgt_pkg::ActAddEdge, 4'd0, 4'd15);
    send_word(dfgt_pkg::ActAddEdge, 4'd15, 4'd0);
    send_word(dfgt_pkg::ActAddEdge, 4'd0, 4'd15);
    send_word(dfgt_pkg::ActAddEdge, 4'd15, 4'd15);
    send_word(dfgt_pkg::ActAddEdge, 4'd3, 4'd9);
    send_word(dfgt_pkg::ActTraverse, 4'd15, 4'd15);
    send_word(ActUnused, 4'd15, 4'd15);
    send_word(dfgt_pkg::ActClear, 4'd0, 4'd0);
    send_word(dfgt_pkg::ActTraverse, 4'd0, 4'd0);
  endtask

  // An empty graph gives no output at all; register values above sixteen are
  // clamped; a single vertex gives a single word.
  task automatic test_count_limits();
    write_vertex_count(5'd0);
    send_word(dfgt_pkg::ActTraverse, 4'd0, 4'd0);
    send_word(dfgt_pkg::ActAddEdge, 4'd0, 4'd0);
    write_vertex_count(5'd31);
    send_word(dfgt_pkg::ActAddEdge, 4'd0, 4'd1);
    send_word(dfgt_pkg::ActAddEdge, 4'd1, 4'd0);
    send_word(dfgt_pkg::ActTraverse, 4'd0, 4'd0);
    write_vertex_count(5'd1);
    send_word(dfgt_pkg::ActTraverse, 4'd0, 4'd0);
  endtask

  // Edges stored at sixteen vertices stay in the lists after the count is lowered,
  // and the traversal must skip the ones that now point out of range.
  task automatic test_stale_neighbors();
    write_vertex_count(5'd16);
    send_word(dfgt_pkg::ActClear, 4'd0, 4'd0);
    send_word(dfgt_pkg::ActAddEdge, 4'd0, 4'd12);
    send_word(dfgt_pkg::ActAddEdge, 4'd0, 4'd3);
    send_word(dfgt_pkg::ActAddEdge, 4'd12, 4'd1);
    write_vertex_count(5'd5);
    send_word(dfgt_pkg::ActTraverse, 4'd0, 4'd0);
    send_word(dfgt_pkg::ActAddEdge, 4'd0, 4'd7);
    send_word(dfgt_pkg::ActTraverse, 4'd0, 4'd0);
  endtask

  // Random graphs under several vertex counts. Most words add in-range edges so
  // that walks get deep; traversals, clears, out-of-range edges and the unused
  // action are mixed in.
  task automatic test_random_graphs();
    logic [dfgt_pkg::CountW-1:0] counts [8];
    int unsigned                 n;
    int unsigned                 pick;
    logic [dfgt_pkg::VtxW-1:0]   src;
    logic [dfgt_pkg::VtxW-1:0]   dst;
    counts = '{5'd16, 5'd31, 5'd2, 5'd9, 5'd16, 5'd5, 5'd12, 5'd0};
    counts[7] = dfgt_pkg::CountW'($urandom_range(1, 31));
    for (int phase = 0; phase < 8; phase++) begin
      write_vertex_count(counts[phase]);
      // One phase runs with no idle cycles on either side.
      gapless = (phase == 4);
      n = live_vertices();
      if (phase % 2 == 0) send_word(dfgt_pkg::ActClear, 4'd0, 4'd0);
      for (int i = 0; i < 36; i++) begin
        pick = $urandom_range(0, 99);
        src = dfgt_pkg::VtxW'($urandom_range(0, n - 1));
        dst = dfgt_pkg::VtxW'($urandom_range(0, n - 1));
        if (pick < 72) begin
          send_word(dfgt_pkg::ActAddEdge, src, dst);
        end else if (pick < 88) begin
          send_word(dfgt_pkg::ActTraverse, dfgt_pkg::VtxW'($urandom),
                    dfgt_pkg::VtxW'($urandom));
        end else if (pick < 94) begin
          send_word(dfgt_pkg::ActAddEdge, dfgt_pkg::VtxW'($urandom),
                    dfgt_pkg::VtxW'($urandom));
        end else if (pick < 97) begin
          send_word(dfgt_pkg::ActClear, dfgt_pkg::VtxW'($urandom),
                    dfgt_pkg::VtxW'($urandom));
        end else begin
          send_word(ActUnused, dfgt_pkg::VtxW'($urandom), dfgt_pkg::VtxW'($urandom));
        end
      end
      send_word(dfgt_pkg::ActTraverse, 4'd0, 4'd0);
      gapless = 1'b0;
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    action_i       = dfgt_pkg::ActAddEdge;
    from_vertex_i  = '0;
    to_vertex_i    = '0;
    out_ready_i    = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_data_i     = '0;
    gapless        = 1'b0;
    mismatch_count = 0;
    shadow_count   = dfgt_pkg::VertexCountReset;
    for (int i = 0; i < MaxVtx; i++) adj_len[i] = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_basic_walks();
    test_count_limits();
    test_stale_neighbors();
    test_random_graphs();

    drain_and_settle();
    if (mismatch_count == 0 && pending_visits.size() == 0) begin
      $display("depth_first_graph_traversal_unit_tb: clean");
    end else begin
      $display("depth_first_graph_traversal_unit_tb: errors");
    end
    $finish;
  end

endmodule
